// ----- hdl/stereo_convolution_reverb_macros.svh -----
// ----------------------------------------------------------------------------
// stereo convolution reverb assertion macros
// shared concurrent assertion wrappers, clocked on clk
// ----------------------------------------------------------------------------
`ifndef STEREO_CONVOLUTION_REVERB_MACROS_SVH
`define STEREO_CONVOLUTION_REVERB_MACROS_SVH

// checked only outside reset
`define SCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SCR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/scr_pkg.sv -----
// ----------------------------------------------------------------------------
// scr_pkg
// shared types, codes and defaults of the stereo convolution reverb
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int unsigned MAX_TAPS_DEF    = 32768;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned TAP_BITS_DEF    = 18;
  localparam int unsigned TAP_INDEX_BITS  = 15;
  localparam int unsigned TAP_COUNT_BITS  = 16;
  localparam int unsigned CFG_ADDR_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS   = 32;

  // register index, taken from the word address
  typedef enum logic [0:0] {
    REG_BYPASS    = 1'b0,
    REG_TAP_COUNT = 1'b1
  } reg_idx_t;

  // item kind on the input stream
  typedef enum logic [0:0] {
    REQ_SAMPLE = 1'b0,
    REQ_TAP    = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIST,
    ST_MAC,
    ST_ROUND,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic tap_wr;
    logic hist_wr;
    logic mac_start;
    logic issue;
    logic round;
    logic out_ld;
    logic byp;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_done;
    logic pipe_busy;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- hdl/stereo_convolution_reverb.sv -----
// ----------------------------------------------------------------------------
// stereo_convolution_reverb
// direct-form long fir reverb per channel with saturation and bypass
// ----------------------------------------------------------------------------
// sample item: accepted in idle, then history write, mac sweep over the effective tap
// count n, rounding and output load; bypassed samples skip to the output load; the
// next item is taken only after that load; the sweep runs one multiply-accumulate per
// channel per cycle on the single read ports; tap writes retire in the accept cycle
// synchronous active-low reset clears control state and the history fill count;
// no clearing pass, unwritten history reads as zero through the fill count
module stereo_convolution_reverb #(
  parameter int unsigned MAX_TAPS    = scr_pkg::MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = scr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TAP_BITS    = scr_pkg::TAP_BITS_DEF,
  localparam int unsigned IN_FIELDS  = scr_pkg::TAP_INDEX_BITS + 2 * SAMPLE_BITS
                                       + 2 * TAP_BITS,
  localparam int unsigned IN_W       = ((IN_FIELDS + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tap_index, left_sample, right_sample, left_tap, right_tap, zero pad
  input  logic [IN_W-1:0]                   in_tdata,
  // req_type
  input  logic                              in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // left_out, right_out, zero pad
  output logic [OUT_W-1:0]                  out_tdata,
  // clipped
  output logic                              out_tuser,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [scr_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [scr_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [scr_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                              cfg_pready
);

  // field offsets inside in_tdata, lowest first
  localparam int unsigned LS_LO = scr_pkg::TAP_INDEX_BITS;
  localparam int unsigned RS_LO = LS_LO + SAMPLE_BITS;
  localparam int unsigned LT_LO = RS_LO + SAMPLE_BITS;
  localparam int unsigned RT_LO = LT_LO + TAP_BITS;
  localparam logic [scr_pkg::TAP_COUNT_BITS-1:0] TAP_COUNT_RST =
    scr_pkg::TAP_COUNT_BITS'((MAX_TAPS > 65535) ? 65535 : MAX_TAPS);

  logic                               bypass_r, bypass_nxt;
  logic [scr_pkg::TAP_COUNT_BITS-1:0] tap_count_r, tap_count_nxt;
  logic                               cfg_wr;
  scr_pkg::reg_idx_t                  cfg_idx;

  scr_pkg::dp_cmd_t  cmd;
  scr_pkg::dp_stat_t stat;

  logic signed [SAMPLE_BITS-1:0] res_left, res_right;

  // register file: a write lands on the access phase of the transaction
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = scr_pkg::reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    bypass_nxt    = bypass_r;
    tap_count_nxt = tap_count_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        scr_pkg::REG_BYPASS:    bypass_nxt    = cfg_pwdata[0];
        scr_pkg::REG_TAP_COUNT: tap_count_nxt = cfg_pwdata[scr_pkg::TAP_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      scr_pkg::REG_BYPASS:
        cfg_prdata = scr_pkg::CFG_DATA_BITS'(bypass_r);
      scr_pkg::REG_TAP_COUNT:
        cfg_prdata = scr_pkg::CFG_DATA_BITS'(tap_count_r);
      default:
        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r    <= 1'b0;
      tap_count_r <= TAP_COUNT_RST;
    end else begin
      bypass_r    <= bypass_nxt;
      tap_count_r <= tap_count_nxt;
    end
  end

  // sequencer: one item at a time, tap writes retire in the accept cycle
  scr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_req_type (in_tuser),
    .bypass      (bypass_r),
    .stat        (stat),
    .in_ready    (in_tready),
    .cmd         (cmd)
  );

  // memories, mac lanes and the output register
  scr_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TAP_BITS    (TAP_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .tap_count       (tap_count_r),
    .in_tap_index    (in_tdata[scr_pkg::TAP_INDEX_BITS-1:0]),
    .in_left_sample  (in_tdata[LS_LO +: SAMPLE_BITS]),
    .in_right_sample (in_tdata[RS_LO +: SAMPLE_BITS]),
    .in_left_tap     (in_tdata[LT_LO +: TAP_BITS]),
    .in_right_tap    (in_tdata[RT_LO +: TAP_BITS]),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_left        (res_left),
    .out_right       (res_right),
    .out_clip        (out_tuser)
  );

  assign out_tdata = OUT_W'({res_right, res_left});

endmodule

// ----- hdl/scr_ram.sv -----
// ----------------------------------------------------------------------------
// scr_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module scr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/scr_ctrl.sv -----
// ----------------------------------------------------------------------------
// scr_ctrl
// sequencer: accepts items, runs history write, mac sweep, rounding, output
// ----------------------------------------------------------------------------
module scr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  input  logic              bypass,
  input  scr_pkg::dp_stat_t stat,
  output logic              in_ready,
  output scr_pkg::dp_cmd_t  cmd
);

  scr_pkg::state_t state_r, state_nxt;
  logic            byp_r, byp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scr_pkg::ST_IDLE;
      byp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      byp_r   <= byp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    byp_nxt   = byp_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      scr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (scr_pkg::req_t'(in_req_type) == scr_pkg::REQ_TAP) begin
            cmd.tap_wr = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            byp_nxt   = bypass;
            state_nxt = bypass ? scr_pkg::ST_DONE : scr_pkg::ST_HIST;
          end
        end
      end
      scr_pkg::ST_HIST: begin
        cmd.hist_wr   = 1'b1;
        cmd.mac_start = 1'b1;
        state_nxt     = scr_pkg::ST_MAC;
      end
      scr_pkg::ST_MAC: begin
        cmd.issue = !stat.issue_done;
        if (stat.issue_done && !stat.pipe_busy) begin
          state_nxt = scr_pkg::ST_ROUND;
        end
      end
      scr_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = scr_pkg::ST_DONE;
      end
      scr_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_ld = 1'b1;
          cmd.byp    = byp_r;
          state_nxt  = scr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/scr_datapath.sv -----
// ----------------------------------------------------------------------------
// scr_datapath
// history and tap memories, two mac lanes, rounding, saturation, output reg
// ----------------------------------------------------------------------------
`include "stereo_convolution_reverb_macros.svh"

module scr_datapath #(
  parameter int unsigned MAX_TAPS    = scr_pkg::MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = scr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TAP_BITS    = scr_pkg::TAP_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  scr_pkg::dp_cmd_t                      cmd,
  output scr_pkg::dp_stat_t                     stat,
  input  logic [scr_pkg::TAP_COUNT_BITS-1:0]    tap_count,
  input  logic [scr_pkg::TAP_INDEX_BITS-1:0]    in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0]         in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]         in_right_sample,
  input  logic signed [TAP_BITS-1:0]            in_left_tap,
  input  logic signed [TAP_BITS-1:0]            in_right_tap,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [SAMPLE_BITS-1:0]         out_left,
  output logic signed [SAMPLE_BITS-1:0]         out_right,
  output logic                                  out_clip
);

  localparam int unsigned AW   = $clog2(MAX_TAPS);
  localparam int unsigned CW   = $clog2(MAX_TAPS + 1);
  localparam int unsigned PW   = SAMPLE_BITS + TAP_BITS;
  localparam int unsigned ACCW = PW + CW + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] FULL     = CW'(MAX_TAPS);
  localparam logic signed [ACCW-1:0] HALF   = ACCW'(64'd1 << (TAP_BITS - 2));
  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ACCW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_ZERO = '0;

  // control state
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          v1_r, v2_r, hv1_r;
  logic          out_valid_r, out_valid_nxt;

  // payload
  logic signed [SAMPLE_BITS-1:0] smp_r [2];
  logic signed [PW-1:0]          prod_r [2];
  logic signed [ACCW-1:0]        acc_r [2];
  logic signed [ACCW-1:0]        rnd_r [2];
  logic signed [SAMPLE_BITS-1:0] out_smp_r [2];
  logic                          out_clip_r;

  logic [CW-1:0]                 n_eff;
  logic                          tap_we;
  logic [2*SAMPLE_BITS-1:0]      hist_q;
  logic [2*TAP_BITS-1:0]         tap_q;
  logic signed [SAMPLE_BITS-1:0] hist_smp [2];
  logic signed [TAP_BITS-1:0]    tap_val [2];
  logic signed [SAMPLE_BITS-1:0] sat_val [2];
  logic [1:0]                    sat_hit;

  // effective tap count, capped at the history depth
  assign n_eff = (32'(tap_count) > 32'(MAX_TAPS)) ? FULL : CW'(tap_count);
  assign tap_we = cmd.tap_wr && (32'(in_tap_index) < 32'(MAX_TAPS));

  scr_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (cmd.hist_wr),
    .waddr (ptr_r),
    .wdata ({smp_r[1], smp_r[0]}),
    .re    (cmd.issue),
    .raddr (rd_addr_r),
    .rdata (hist_q)
  );

  scr_ram #(
    .WIDTH (2 * TAP_BITS),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (AW'(in_tap_index)),
    .wdata ({in_right_tap, in_left_tap}),
    .re    (cmd.issue),
    .raddr (k_r[AW-1:0]),
    .rdata (tap_q)
  );

  assign hist_smp[0] = hist_q[SAMPLE_BITS-1:0];
  assign hist_smp[1] = hist_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign tap_val[0]  = tap_q[TAP_BITS-1:0];
  assign tap_val[1]  = tap_q[2*TAP_BITS-1:TAP_BITS];

  always_comb begin
    ptr_nxt     = ptr_r;
    fill_nxt    = fill_r;
    rd_addr_nxt = rd_addr_r;
    k_nxt       = k_r;
    if (cmd.hist_wr && (fill_r != FULL)) begin
      fill_nxt = fill_r + CW'(1);
    end
    if (cmd.round) begin
      ptr_nxt = (ptr_r == LAST_ADDR) ? '0 : ptr_r + AW'(1);
    end
    if (cmd.mac_start) begin
      rd_addr_nxt = ptr_r;
      k_nxt       = '0;
    end else if (cmd.issue) begin
      rd_addr_nxt = (rd_addr_r == '0) ? LAST_ADDR : rd_addr_r - AW'(1);
      k_nxt       = k_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      fill_r      <= '0;
      rd_addr_r   <= '0;
      k_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      hv1_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      rd_addr_r   <= rd_addr_nxt;
      k_r         <= k_nxt;
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      // entries beyond the fill count were never written since reset
      hv1_r       <= CW'(rd_addr_r) < fill_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (rnd_r[c] > SAT_HI) begin
        sat_val[c] = SAT_HI[SAMPLE_BITS-1:0];
        sat_hit[c] = 1'b1;
      end else if (rnd_r[c] < SAT_LO) begin
        sat_val[c] = SAT_LO[SAMPLE_BITS-1:0];
        sat_hit[c] = 1'b1;
      end else begin
        sat_val[c] = rnd_r[c][SAMPLE_BITS-1:0];
        sat_hit[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r[0] <= in_left_sample;
      smp_r[1] <= in_right_sample;
    end
    for (int c = 0; c < 2; c++) begin
      if (v1_r) begin
        prod_r[c] <= (hv1_r ? hist_smp[c] : SMP_ZERO) * tap_val[c];
      end
      if (cmd.mac_start) begin
        acc_r[c] <= '0;
      end else if (v2_r) begin
        acc_r[c] <= acc_r[c] + ACCW'(prod_r[c]);
      end
      if (cmd.round) begin
        rnd_r[c] <= (acc_r[c] + HALF) >>> (TAP_BITS - 1);
      end
      if (cmd.out_ld) begin
        out_smp_r[c] <= cmd.byp ? smp_r[c] : sat_val[c];
      end
    end
    if (cmd.out_ld) begin
      out_clip_r <= cmd.byp ? 1'b0 : |sat_hit;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign stat.issue_done = (k_r == n_eff);
  assign stat.pipe_busy  = v1_r || v2_r;
  assign stat.out_busy   = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_left  = out_smp_r[0];
  assign out_right = out_smp_r[1];
  assign out_clip  = out_clip_r;

  `SCR_ASSERT(a_fill_bound, fill_r <= FULL, "history fill count beyond depth")
  `SCR_ASSERT(a_issue_in_range, cmd.issue |-> (k_r < n_eff), "tap read past tap count")
  `SCR_ASSERT(a_hist_fill, cmd.hist_wr |=> (fill_r != '0), "history write left fill empty")
  `SCR_ASSERT(a_no_ld_busy, cmd.out_ld |-> !(out_valid_r && !out_ready), "result overwrote an untaken result")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stereo convolution reverb: a mirror of the
// per-channel fir, rounding and saturation predicts each result, which is
// compared against the result stream under random idling and backpressure
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned N_TAPS   = scr_pkg::MAX_TAPS_DEF;
  localparam int unsigned IN_W     = 88;
  localparam int unsigned OUT_W    = 32;
  localparam int          SAT_MAX  = 32767;
  localparam int          SAT_MIN  = -32768;
  localparam int unsigned DRAIN_PAUSE = 16;
  localparam longint      CYCLE_LIMIT = 400_000;

  // one predicted result transaction
  typedef struct {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               clipped;
  } mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [scr_pkg::CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [scr_pkg::CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [scr_pkg::CFG_DATA_BITS-1:0] cfg_prdata;
  logic             cfg_pready;

  // mirror of the block state
  logic signed [15:0] hist_left  [N_TAPS];
  logic signed [15:0] hist_right [N_TAPS];
  logic signed [17:0] ir_left    [N_TAPS];
  logic signed [17:0] ir_right   [N_TAPS];
  int unsigned        hist_ptr;
  logic               bypass_on;
  int unsigned        taps_in_use;

  mix_t   pending_mix[$];
  int     fail_count = 0;
  longint cycle_count = 0;
  bit     send_gaps = 1'b0;
  bit     recv_stalls = 1'b0;
  int     hold_request = 0;

  stereo_convolution_reverb dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // one channel of the fir: exact sum, round half up, clamp to q1.15
  function automatic logic signed [15:0] fir_channel(input bit is_left, inout logic clip);
    longint acc;
    longint v;
    int unsigned k;
    int unsigned idx;
    acc = 0;
    for (k = 0; k < taps_in_use; k++) begin
      idx = (hist_ptr - k) % N_TAPS;
      if (is_left)
        acc += longint'(hist_left[idx]) * longint'(ir_left[k]);
      else
        acc += longint'(hist_right[idx]) * longint'(ir_right[k]);
    end
    v = (acc + (longint'(1) << 16)) >>> 17;
    if (v > SAT_MAX) begin
      clip = 1'b1;
      return 16'sh7fff;
    end
    if (v < SAT_MIN) begin
      clip = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // mirror of one accepted sample pair
  function automatic mix_t reverb_predict(logic signed [15:0] ls, logic signed [15:0] rs);
    mix_t m;
    logic clip;
    clip = 1'b0;
    if (bypass_on) begin
      m.left_out  = ls;
      m.right_out = rs;
      m.clipped   = 1'b0;
      return m;
    end
    hist_left[hist_ptr]  = ls;
    hist_right[hist_ptr] = rs;
    m.left_out  = fir_channel(1'b1, clip);
    m.right_out = fir_channel(1'b0, clip);
    m.clipped   = clip;
    hist_ptr = (hist_ptr + 1) % N_TAPS;
    return m;
  endfunction

  // send one transaction and update the mirror once it is taken
  task automatic send_item(scr_pkg::req_t kind, logic [14:0] tap_idx,
                           logic signed [15:0] ls, logic signed [15:0] rs,
                           logic signed [17:0] lt, logic signed [17:0] rt);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    // tap_index, left_sample, right_sample, left_tap, right_tap, zero pad
    in_tdata  <= {5'b0, rt, lt, rs, ls, tap_idx};
    do @(posedge clk); while (!in_tready);
    if (kind == scr_pkg::REQ_TAP) begin
      ir_left[tap_idx]  = lt;
      ir_right[tap_idx] = rt;
    end else begin
      pending_mix.push_back(reverb_predict(ls, rs));
    end
  endtask

  task automatic send_pair(logic signed [15:0] ls, logic signed [15:0] rs);
    send_item(scr_pkg::REQ_SAMPLE, 15'($urandom), ls, rs, 18'($urandom), 18'($urandom));
  endtask

  task automatic send_tap(logic [14:0] tap_idx, logic signed [17:0] lt,
                          logic signed [17:0] rt);
    send_item(scr_pkg::REQ_TAP, tap_idx, 16'($urandom), 16'($urandom), lt, rt);
  endtask

  // let all results come home, then allow trailing tap writes to retire
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic cfg_write(scr_pkg::reg_idx_t idx, logic [31:0] value);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == scr_pkg::REG_BYPASS)
      bypass_on = value[0];
    else
      taps_in_use = (value[15:0] > N_TAPS) ? N_TAPS : value[15:0];
  endtask

  // result checker
  always @(posedge clk) begin
    mix_t m;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_mix.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        fail_count++;
      end else begin
        m = pending_mix.pop_front();
        if (out_tdata[15:0] !== m.left_out) begin
          $error("left_out expected %0d actual %0d", m.left_out, $signed(out_tdata[15:0]));
          fail_count++;
        end
        if (out_tdata[31:16] !== m.right_out) begin
          $error("right_out expected %0d actual %0d", m.right_out,
                 $signed(out_tdata[31:16]));
          fail_count++;
        end
        if (out_tuser !== m.clipped) begin
          $error("clipped expected %0b actual %0b", m.clipped, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // result-side ready: random stall bursts, or one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_tready <= 1'b0;
        n = hold_request;
        hold_request = 0;
        repeat (n) @(posedge clk);
      end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // full-scale taps and samples drive both rails, plus a quiet half-gain check
  task automatic test_saturation();
    cfg_write(scr_pkg::REG_TAP_COUNT, 32'd4);
    send_tap(15'd0, 18'sh1ffff, 18'sh20000);
    send_tap(15'd1, 18'sh1ffff, 18'sh20000);
    send_tap(15'd2, 18'sh20000, 18'sh1ffff);
    send_tap(15'd3, 18'sd0, 18'sd0);
    send_pair(16'sh7fff, 16'sh7fff);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd1, -16'sd1);
    send_tap(15'd0, 18'sh10000, 18'sh10000);
    cfg_write(scr_pkg::REG_TAP_COUNT, 32'd1);
    send_pair(16'sh1234, -16'sh1234);
    send_pair(16'sd1, -16'sd1);
  endtask

  // pass-through ignores history and never flags clipping
  task automatic test_bypass();
    cfg_write(scr_pkg::REG_BYPASS, 32'd1);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh5a5a, -16'sh5a5a);
    cfg_write(scr_pkg::REG_BYPASS, 32'd0);
    send_pair(16'sd100, 16'sd200);
  endtask

  // empty sum gives silence
  task automatic test_zero_taps();
    cfg_write(scr_pkg::REG_TAP_COUNT, 32'd0);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh1111, 16'sh2222);
  endtask

  task automatic random_pair();
    logic signed [15:0] ls;
    logic signed [15:0] rs;
    ls = 16'($urandom);
    rs = 16'($urandom);
    if ($urandom_range(0, 1)) begin
      ls = ls >>> $urandom_range(0, 12);
      rs = rs >>> $urandom_range(0, 12);
    end
    send_pair(ls, rs);
  endtask

  task automatic random_tap(logic [14:0] tap_idx);
    send_tap(tap_idx, 18'($signed(18'($urandom)) >>> $urandom_range(0, 10)),
             18'($signed(18'($urandom)) >>> $urandom_range(0, 10)));
  endtask

  // random taps, samples and settings with idling on both sides
  task automatic test_random();
    int i;
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    for (i = 0; i < 64; i++) random_tap(15'(i));
    cfg_write(scr_pkg::REG_TAP_COUNT, 32'd64);
    for (i = 0; i < 176; i++) begin
      if (i % 40 == 39) begin
        cfg_write(scr_pkg::REG_BYPASS, ($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0);
        cfg_write(scr_pkg::REG_TAP_COUNT, 32'($urandom_range(0, 64)));
      end
      if ($urandom_range(0, 9) < 7)
        random_pair();
      else
        random_tap(15'($urandom_range(0, 63)));
    end
    cfg_write(scr_pkg::REG_BYPASS, 32'd0);
  endtask

  // receiver holds off while samples keep coming, so the input backs up
  task automatic test_backpressure();
    int i;
    cfg_write(scr_pkg::REG_TAP_COUNT, 32'd8);
    hold_request = 800;
    for (i = 0; i < 12; i++) random_pair();
  endtask

  // back-to-back samples over every loaded tap with no idling on either side
  task automatic test_steady_tail();
    int i;
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    cfg_write(scr_pkg::REG_TAP_COUNT, 32'd64);
    for (i = 0; i < 20; i++) random_pair();
  endtask

  initial begin
    for (int i = 0; i < N_TAPS; i++) begin
      hist_left[i]  = '0;
      hist_right[i] = '0;
      ir_left[i]    = '0;
      ir_right[i]   = '0;
    end
    hist_ptr    = 0;
    bypass_on   = 1'b0;
    taps_in_use = N_TAPS;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_saturation();
    test_bypass();
    test_zero_taps();
    test_random();
    test_backpressure();
    test_steady_tail();
    wait_drained();
    repeat (64) @(posedge clk);
    if (fail_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
